### hw/rtl/kgbl_pkg.sv
`default_nettype none

package kgbl_pkg;

  // Field widths of the keypoint and result beats.
  localparam int X_W     = 12;
  localparam int Y_W     = 12;
  localparam int ID_W    = 16;
  localparam int CELL_W  = 5;

  // Configuration register widths.
  localparam int CFG_W     = 13;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 3;

  // Grid indices inside the block are wide enough for 256 rows or columns.
  localparam int IDX_W = 8;

  // Divider geometry: quotient bits, divisor bits and bits retired per cycle.
  localparam int QUOT_W    = 12;
  localparam int DIV_W     = 13;
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = QUOT_W / STEP_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Image generation tag kept beside each cell count.
  localparam int EPOCH_W = 8;

  // Configuration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATCH_WIDTH     = 0,
    CFG_PATCH_HEIGHT    = 1,
    CFG_PER_PATCH_LIMIT = 2,
    CFG_IMAGE_WIDTH     = 3,
    CFG_IMAGE_HEIGHT    = 4
  } cfg_reg_t;

  // One keypoint beat.
  typedef struct packed {
    logic [X_W-1:0]  point_x;
    logic [Y_W-1:0]  point_y;
    logic [ID_W-1:0] point_id;
    logic            new_image;
  } point_t;

  // One result beat.
  typedef struct packed {
    logic              kept;
    logic              outside_grid;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic [ID_W-1:0]   id_out;
  } result_t;

  // A classified keypoint passed from the front end to the back end.
  typedef struct packed {
    logic             outside;
    logic             new_image;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ID_W-1:0]  id;
  } cls_item_t;

  typedef enum logic {
    F_IDLE,
    F_WAIT
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_WRITE
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/kgbl_divider.sv
`default_nettype none

module kgbl_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [kgbl_pkg::QUOT_W-1:0] dividend,
  input  wire logic [kgbl_pkg::DIV_W-1:0]  divisor,
  output logic                             done,
  output logic [kgbl_pkg::QUOT_W-1:0]      quotient,
  output logic [kgbl_pkg::QUOT_W-1:0]      remainder
);

  logic                                busy;
  logic [kgbl_pkg::STEP_CNT_W-1:0]     step_cnt;
  logic [kgbl_pkg::QUOT_W-1:0]         dvd;
  logic [kgbl_pkg::QUOT_W-1:0]         dvd_next;
  logic [kgbl_pkg::QUOT_W-1:0]         quot;
  logic [kgbl_pkg::QUOT_W-1:0]         quot_next;
  logic [kgbl_pkg::DIV_W-1:0]          rem;
  logic [kgbl_pkg::DIV_W-1:0]          rem_next;
  logic [kgbl_pkg::DIV_W-1:0]          dsr;
  logic [kgbl_pkg::DIV_W:0]            trial;

  // Restoring division, several quotient bits per cycle, most significant first.
  always_comb begin
    rem_next  = rem;
    dvd_next  = dvd;
    quot_next = quot;
    trial     = '0;
    for (int i = 0; i < kgbl_pkg::STEP_BITS; i++) begin
      trial    = {rem_next, dvd_next[kgbl_pkg::QUOT_W-1]};
      dvd_next = {dvd_next[kgbl_pkg::QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial     = trial - {1'b0, dsr};
        quot_next = {quot_next[kgbl_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[kgbl_pkg::QUOT_W-2:0], 1'b0};
      end
      rem_next = trial[kgbl_pkg::DIV_W-1:0];
    end
  end

  // Control: a start loads the operands, then the step counter runs down to zero and done is raised.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      step_cnt <= kgbl_pkg::STEP_CNT_W'(kgbl_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      if (step_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step_cnt <= step_cnt - 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= dvd_next;
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  // The remainder never exceeds the dividend, so its low bits hold it whole.
  assign quotient  = quot;
  assign remainder = rem[kgbl_pkg::QUOT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/kgbl_fifo.sv
`default_nettype none

module kgbl_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      rd_item,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kgbl_front.sv
`default_nettype none

module kgbl_front #(
  parameter int MAX_GRID_ROWS = 32,
  parameter int MAX_GRID_COLS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire kgbl_pkg::point_t           point,
  output logic                            full,
  input  wire logic                       clearing,
  input  wire logic [kgbl_pkg::CFG_W-1:0] patch_width,
  input  wire logic [kgbl_pkg::CFG_W-1:0] patch_height,
  input  wire logic [kgbl_pkg::CFG_W-1:0] image_width,
  input  wire logic [kgbl_pkg::CFG_W-1:0] image_height,
  output logic                            mid_push,
  output kgbl_pkg::cls_item_t             mid_item,
  input  wire logic                       mid_full
);

  kgbl_pkg::front_state_t              state;
  kgbl_pkg::front_state_t              state_next;
  kgbl_pkg::point_t                    pt;
  logic                                accept;
  logic [kgbl_pkg::CFG_W-1:0]          pw_eff;
  logic [kgbl_pkg::CFG_W-1:0]          ph_eff;
  logic                                x_done;
  logic                                y_done;
  logic [kgbl_pkg::QUOT_W-1:0]         col_q;
  logic [kgbl_pkg::QUOT_W-1:0]         row_q;
  logic [kgbl_pkg::QUOT_W-1:0]         x_rem;
  logic [kgbl_pkg::QUOT_W-1:0]         y_rem;
  logic [kgbl_pkg::X_W-1:0]            base_x;
  logic [kgbl_pkg::Y_W-1:0]            base_y;
  logic                                out_col;
  logic                                out_row;
  logic                                outside;
  logic                                div_done;

  // A zero patch size behaves as one pixel.
  assign pw_eff = (patch_width == '0) ? kgbl_pkg::CFG_W'(1) : patch_width;
  assign ph_eff = (patch_height == '0) ? kgbl_pkg::CFG_W'(1) : patch_height;

  assign accept   = push && !full;
  assign div_done = x_done && y_done;

  // Column and row quotients run side by side.
  kgbl_divider u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (point.point_x),
    .divisor   (pw_eff),
    .done      (x_done),
    .quotient  (col_q),
    .remainder (x_rem)
  );

  kgbl_divider u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (point.point_y),
    .divisor   (ph_eff),
    .done      (y_done),
    .quotient  (row_q),
    .remainder (y_rem)
  );

  // Grid bounds: column c lies inside the grid exactly when c * patch_width
  // is below the image width and c is below MAX_GRID_COLS, and c * patch_width
  // is the point less its remainder, so no second division is needed.
  assign base_x  = pt.point_x - x_rem;
  assign base_y  = pt.point_y - y_rem;
  assign out_col = (image_width == '0) || ({1'b0, base_x} >= image_width) ||
                   ({1'b0, col_q} >= kgbl_pkg::CFG_W'(MAX_GRID_COLS));
  assign out_row = (image_height == '0) || ({1'b0, base_y} >= image_height) ||
                   ({1'b0, row_q} >= kgbl_pkg::CFG_W'(MAX_GRID_ROWS));
  assign outside = out_col || out_row;

  // Classified beat for the back end.
  always_comb begin
    mid_item.outside   = outside;
    mid_item.new_image = pt.new_image;
    mid_item.row       = outside ? '0 : row_q[kgbl_pkg::IDX_W-1:0];
    mid_item.col       = outside ? '0 : col_q[kgbl_pkg::IDX_W-1:0];
    mid_item.id        = pt.point_id;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kgbl_pkg::F_IDLE: begin
        if (accept) begin
          state_next = kgbl_pkg::F_WAIT;
        end
      end
      kgbl_pkg::F_WAIT: begin
        if (div_done && !mid_full) begin
          state_next = kgbl_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = kgbl_pkg::F_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    full     = (state != kgbl_pkg::F_IDLE) || clearing;
    mid_push = (state == kgbl_pkg::F_WAIT) && div_done && !mid_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kgbl_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the keypoint while its division runs.
  always_ff @(posedge clk) begin
    if (accept) begin
      pt <= point;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kgbl_back.sv
`default_nettype none

module kgbl_back #(
  parameter int MAX_GRID_ROWS = 32,
  parameter int MAX_GRID_COLS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         mid_empty,
  input  wire kgbl_pkg::cls_item_t          mid_item,
  output logic                              mid_pop,
  input  wire logic [kgbl_pkg::LIMIT_W-1:0] limit,
  input  wire logic                         res_full,
  output logic                              res_push,
  output kgbl_pkg::result_t                 res_item,
  output logic                              clearing
);

  localparam int CELLS   = MAX_GRID_ROWS * MAX_GRID_COLS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENTRY_W = kgbl_pkg::EPOCH_W + kgbl_pkg::LIMIT_W;

  kgbl_pkg::back_state_t           state;
  kgbl_pkg::back_state_t           state_next;
  kgbl_pkg::cls_item_t             item;
  logic [kgbl_pkg::EPOCH_W-1:0]    epoch;
  logic [ADDR_W-1:0]               clr_addr;
  logic                            clr_last;
  logic                            held;
  logic                            take;
  logic                            wrap;
  logic [ADDR_W-1:0]               item_addr;
  logic [ENTRY_W-1:0]              cell_mem [CELLS];
  logic [ENTRY_W-1:0]              rd_data;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [ENTRY_W-1:0]              mem_wdata;
  logic                            mem_re;
  logic                            tag_hit;
  logic [kgbl_pkg::LIMIT_W-1:0]    cur_count;
  logic                            keep;

  assign clr_last  = (clr_addr == ADDR_W'(CELLS - 1));
  assign take      = (state == kgbl_pkg::B_IDLE) && !mid_empty && !res_full;
  assign wrap      = mid_item.new_image && (epoch == '1);
  assign item_addr = ADDR_W'(int'(item.row) * MAX_GRID_COLS + int'(item.col));

  // A count belongs to the current image only if its tag matches.
  assign tag_hit   = (rd_data[ENTRY_W-1:kgbl_pkg::LIMIT_W] == epoch);
  assign cur_count = tag_hit ? rd_data[kgbl_pkg::LIMIT_W-1:0] : '0;
  assign keep      = !item.outside && (cur_count < limit);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kgbl_pkg::B_CLEAR: begin
        if (clr_last) begin
          state_next = held ? kgbl_pkg::B_READ : kgbl_pkg::B_IDLE;
        end
      end
      kgbl_pkg::B_IDLE: begin
        if (take) begin
          state_next = wrap ? kgbl_pkg::B_CLEAR : kgbl_pkg::B_READ;
        end
      end
      kgbl_pkg::B_READ: begin
        state_next = kgbl_pkg::B_WRITE;
      end
      kgbl_pkg::B_WRITE: begin
        state_next = kgbl_pkg::B_IDLE;
      end
      default: begin
        state_next = kgbl_pkg::B_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    mid_pop   = take;
    clearing  = (state == kgbl_pkg::B_CLEAR);
    mem_re    = (state == kgbl_pkg::B_READ);
    res_push  = (state == kgbl_pkg::B_WRITE);
    mem_we    = 1'b0;
    mem_waddr = item_addr;
    mem_wdata = {epoch, cur_count + 1'b1};
    if (state == kgbl_pkg::B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == kgbl_pkg::B_WRITE) begin
      mem_we = keep;
    end
    res_item.kept         = keep;
    res_item.outside_grid = item.outside;
    res_item.cell_row     = item.row[kgbl_pkg::CELL_W-1:0];
    res_item.cell_col     = item.col[kgbl_pkg::CELL_W-1:0];
    res_item.id_out       = item.id;
  end

  // Control registers: state, image tag, sweep address and the held flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kgbl_pkg::B_CLEAR;
      epoch    <= '0;
      clr_addr <= '0;
      held     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == kgbl_pkg::B_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        if (clr_last) begin
          epoch <= '0;
        end
      end else if (take && mid_item.new_image && !wrap) begin
        epoch <= epoch + 1'b1;
      end
      if (take) begin
        held <= 1'b1;
      end else if (state == kgbl_pkg::B_WRITE) begin
        held <= 1'b0;
      end
    end
  end

  // Keypoint being worked on.
  always_ff @(posedge clk) begin
    if (take) begin
      item <= mid_item;
    end
  end

  // Cell count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= cell_mem[item_addr];
    end
  end

  // A keypoint beyond the grid is never kept.
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> !(res_item.kept && res_item.outside_grid))
    else $error("kept keypoint flagged outside the grid");

  // The update always follows its own memory read.
  assert property (@(posedge clk) disable iff (rst)
    (state == kgbl_pkg::B_WRITE) |-> ($past(state) == kgbl_pkg::B_READ))
    else $error("cell update without a preceding read");

  // A stored count never passes the limit.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == kgbl_pkg::B_WRITE)) |->
      (mem_wdata[kgbl_pkg::LIMIT_W-1:0] <= limit))
    else $error("cell count exceeds the per-patch limit");

  // Room in the result queue was checked when the keypoint was taken.
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

### hw/rtl/keypoint_grid_bucket_limiter.sv
// A keypoint's result passes the front end's divider steps, the middle queue, a
// cell memory read and a cell update before it enters the result queue. The
// front end takes no new keypoint until its radix-16 divider is done and the
// keypoint is handed to the middle queue. Reset is synchronous; afterwards all
// MAX_GRID_ROWS*MAX_GRID_COLS memory cells (1024 by default) are swept with full
// held high; the same sweep runs once every 256 new images when the image tag wraps.
`default_nettype none

module keypoint_grid_bucket_limiter #(
  parameter int MAX_GRID_ROWS = 32,
  parameter int MAX_GRID_COLS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire kgbl_pkg::point_t               point,
  output logic                                full,
  output kgbl_pkg::result_t                   result,
  output logic                                empty,
  input  wire logic                           pop,
  input  wire logic                           cfg_write,
  input  wire logic [kgbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kgbl_pkg::CFG_W-1:0]     cfg_data
);

  logic [kgbl_pkg::CFG_W-1:0]   patch_width;
  logic [kgbl_pkg::CFG_W-1:0]   patch_height;
  logic [kgbl_pkg::LIMIT_W-1:0] per_patch_limit;
  logic [kgbl_pkg::CFG_W-1:0]   image_width;
  logic [kgbl_pkg::CFG_W-1:0]   image_height;
  logic                         clearing;
  logic                         mid_push;
  logic                         mid_full;
  logic                         mid_pop;
  logic                         mid_empty;
  kgbl_pkg::cls_item_t          mid_in;
  kgbl_pkg::cls_item_t          mid_out;
  logic                         res_push;
  logic                         res_full;
  kgbl_pkg::result_t            res_item;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_width     <= kgbl_pkg::CFG_W'(32);
      patch_height    <= kgbl_pkg::CFG_W'(32);
      per_patch_limit <= kgbl_pkg::LIMIT_W'(4);
      image_width     <= kgbl_pkg::CFG_W'(1280);
      image_height    <= kgbl_pkg::CFG_W'(720);
    end else if (cfg_write) begin
      case (cfg_index)
        kgbl_pkg::CFG_PATCH_WIDTH:     patch_width     <= cfg_data;
        kgbl_pkg::CFG_PATCH_HEIGHT:    patch_height    <= cfg_data;
        kgbl_pkg::CFG_PER_PATCH_LIMIT: per_patch_limit <= cfg_data[kgbl_pkg::LIMIT_W-1:0];
        kgbl_pkg::CFG_IMAGE_WIDTH:     image_width     <= cfg_data;
        kgbl_pkg::CFG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: takes keypoints and works out their grid cell.
  kgbl_front #(
    .MAX_GRID_ROWS (MAX_GRID_ROWS),
    .MAX_GRID_COLS (MAX_GRID_COLS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .point        (point),
    .full         (full),
    .clearing     (clearing),
    .patch_width  (patch_width),
    .patch_height (patch_height),
    .image_width  (image_width),
    .image_height (image_height),
    .mid_push     (mid_push),
    .mid_item     (mid_in),
    .mid_full     (mid_full)
  );

  // Short queue between the two halves.
  kgbl_fifo #(
    .item_t (kgbl_pkg::cls_item_t),
    .DEPTH  (2)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_item (mid_in),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_item (mid_out),
    .empty   (mid_empty)
  );

  // Back end: per-cell counting against the limit.
  kgbl_back #(
    .MAX_GRID_ROWS (MAX_GRID_ROWS),
    .MAX_GRID_COLS (MAX_GRID_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .limit     (per_patch_limit),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item),
    .clearing  (clearing)
  );

  // Result queue facing the consumer.
  kgbl_fifo #(
    .item_t (kgbl_pkg::result_t),
    .DEPTH  (2)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .pop     (pop),
    .rd_item (result),
    .empty   (empty)
  );

endmodule

`default_nettype wire
